// ----- rtl/odo_pkg.sv -----
// ---------------------------------------------------------------------------
// Odometry package
// Shared constants, register indexes and the CORDIC arctangent table.
// ---------------------------------------------------------------------------
`default_nettype none

package odo_pkg;

    // Count and configuration widths
    localparam int COUNT_W = 16;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int POS_W   = 48;
    localparam int HEAD_W  = 32;

    // Serial multiplier widths
    localparam int SUM_W  = COUNT_W + 1;          // left + right, right - left
    localparam int PROD_W = SUM_W + CFG_W;        // sum * meters_per_pulse
    localparam int CS_W   = 34;                   // CORDIC x, y in Q2.30 with margin, z in turns over 2^32
    localparam int ACC_W  = PROD_W + 4;           // scaled product accumulator
    localparam int FRAC_SHIFT = 31;               // result is floor(p * c / 2^31)
    localparam int STEP_CNT_W = 6;

    localparam logic signed [CS_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_METERS_PER_PULSE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_PER_DIFF    = 2'd1;

    localparam logic [CFG_W-1:0] METERS_PER_PULSE_RST = 32'd429497;
    localparam logic [CFG_W-1:0] TURN_PER_DIFF_RST    = 32'd200000;

    // atan(2^-i) as a turn fraction over 2^32
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] r;
        begin
            case (idx)
                5'd0:  r = 32'h20000000;
                5'd1:  r = 32'h12E4051E;
                5'd2:  r = 32'h09FB385B;
                5'd3:  r = 32'h051111D4;
                5'd4:  r = 32'h028B0D43;
                5'd5:  r = 32'h0145D7E1;
                5'd6:  r = 32'h00A2F61E;
                5'd7:  r = 32'h00517C55;
                5'd8:  r = 32'h0028BE53;
                5'd9:  r = 32'h00145F2F;
                5'd10: r = 32'h000A2F98;
                5'd11: r = 32'h000517CC;
                5'd12: r = 32'h00028BE6;
                5'd13: r = 32'h000145F3;
                5'd14: r = 32'h0000A2FA;
                5'd15: r = 32'h0000517D;
                5'd16: r = 32'h000028BE;
                5'd17: r = 32'h0000145F;
                5'd18: r = 32'h00000A30;
                5'd19: r = 32'h00000518;
                5'd20: r = 32'h0000028C;
                5'd21: r = 32'h00000146;
                5'd22: r = 32'h000000A3;
                5'd23: r = 32'h00000051;
                5'd24: r = 32'h00000029;
                5'd25: r = 32'h00000014;
                5'd26: r = 32'h0000000A;
                5'd27: r = 32'h00000005;
                5'd28: r = 32'h00000003;
                5'd29: r = 32'h00000001;
                5'd30: r = 32'h00000001;
                default: r = 32'h00000000;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/diff_drive_odometry_top.sv -----
// ---------------------------------------------------------------------------
// Differential drive odometry top level
// Dead-reckoning pose update from left and right encoder counts.
// ---------------------------------------------------------------------------
// Sequencing: the front multiplier, the CORDIC, the two scalers and the
//   write-back run one after another on a single transaction; a new one is
//   accepted only after the last has been written back, since the serial
//   units handle one item at a time, and a result still held on the
//   output stalls write-back.
// Reset: synchronous active-low aresetn clears the pose, the heading and the
//   handshakes, and loads the configuration registers with their defaults.
`default_nettype none

module diff_drive_odometry_top import odo_pkg::*; #(
    parameter int CORDIC_STEPS = 18
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    // tdata: [15:0] left_count, [31:16] right_count
    input  wire  [31:0]          s_axis_tdata,
    input  wire                  s_axis_tvalid,
    output logic                 s_axis_tready,
    // tdata: [47:0] position_x, [95:48] position_y, [127:96] heading
    output logic [127:0]         m_axis_tdata,
    output logic                 m_axis_tvalid,
    input  wire                  m_axis_tready,
    input  wire                  cfg_wr_en,
    input  wire  [CFG_IDX_W-1:0] cfg_index,
    input  wire  [CFG_W-1:0]     cfg_wdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRE,
        ST_COR,
        ST_SCL,
        ST_WB
    } state_t;

    state_t state_reg;

    // configuration
    logic [CFG_W-1:0] mpp_reg;
    logic [CFG_W-1:0] tpd_reg;

    // pose state
    logic [POS_W-1:0]  pos_x_reg;
    logic [POS_W-1:0]  pos_y_reg;
    logic [HEAD_W-1:0] heading_reg;

    // start pulses to the serial units
    logic pre_start_reg, cor_start_reg, scl_start_reg;

    // hold the accepted counts until the front multiplier loads them
    logic [COUNT_W-1:0] s_hold_left, s_hold_right;

    logic                     pre_done;
    logic [HEAD_W-1:0]        pre_heading;
    logic signed [PROD_W-1:0] pre_prod;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     cor_done;
    logic signed [CS_W-1:0]   cos_val, sin_val;
    logic                     x_done, y_done;
    logic [POS_W-1:0]         dx, dy;
    logic                     s_accept;
    logic                     wb_fire;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    // write back once the output register is free or being emptied
    assign wb_fire       = (state_reg == ST_WB) && (!m_axis_tvalid || m_axis_tready);

    // configuration writes; indexes beyond the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mpp_reg <= METERS_PER_PULSE_RST;
            tpd_reg <= TURN_PER_DIFF_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_METERS_PER_PULSE: mpp_reg <= cfg_wdata;
                REG_TURN_PER_DIFF:    tpd_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // heading step and distance product, one count bit per cycle
    odo_pre u_pre (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .start            (pre_start_reg),
        .left_count       (signed'(s_hold_left)),
        .right_count      (signed'(s_hold_right)),
        .meters_per_pulse (mpp_reg),
        .turn_per_diff    (tpd_reg),
        .heading_in       (heading_reg),
        .done             (pre_done),
        .heading_out      (pre_heading),
        .prod             (pre_prod)
    );

    // one micro-rotation per cycle on the updated heading
    odo_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cor_start_reg),
        .angle   (heading_reg),
        .done    (cor_done),
        .cos_out (cos_val),
        .sin_out (sin_val)
    );

    // distance times cosine and sine, in parallel
    odo_scale u_scale_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (scl_start_reg),
        .p_in    (prod_reg),
        .c_in    (cos_val),
        .done    (x_done),
        .delta   (dx)
    );

    odo_scale u_scale_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (scl_start_reg),
        .p_in    (prod_reg),
        .c_in    (sin_val),
        .done    (y_done),
        .delta   (dy)
    );

    logic [POS_W-1:0] dx_reg, dy_reg;

    // sequencer, pose registers and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pre_start_reg <= 1'b0;
            cor_start_reg <= 1'b0;
            scl_start_reg <= 1'b0;
            m_axis_tvalid <= 1'b0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            heading_reg   <= '0;
        end else begin
            pre_start_reg <= (state_reg == ST_IDLE) && s_accept;
            cor_start_reg <= (state_reg == ST_PRE) && pre_done;
            scl_start_reg <= (state_reg == ST_COR) && cor_done;
            // load a new result, or drop the old one once downstream takes it
            if (wb_fire)
                m_axis_tvalid <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready)
                m_axis_tvalid <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        s_hold_left   <= s_axis_tdata[15:0];
                        s_hold_right  <= s_axis_tdata[31:16];
                        state_reg     <= ST_PRE;
                    end
                end
                ST_PRE: begin
                    if (pre_done) begin
                        heading_reg   <= pre_heading;
                        prod_reg      <= pre_prod;
                        state_reg     <= ST_COR;
                    end
                end
                ST_COR: begin
                    if (cor_done) begin
                        state_reg     <= ST_SCL;
                    end
                end
                ST_SCL: begin
                    if (x_done) begin
                        dx_reg    <= dx;
                        dy_reg    <= dy;
                        state_reg <= ST_WB;
                    end
                end
                ST_WB: begin
                    // advance the pose only when the output register is free
                    if (wb_fire) begin
                        pos_x_reg     <= pos_x_reg + dx_reg;
                        pos_y_reg     <= pos_y_reg + dy_reg;
                        m_axis_tdata  <= {heading_reg, pos_y_reg + dy_reg,
                                          pos_x_reg + dx_reg};
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // both scalers start together and take the same number of cycles
    a_scale_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        x_done == y_done)
        else $error("x and y scalers out of step");

    // a transaction is only taken while the pipeline is empty
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == ST_PRE) && pre_start_reg)
        else $error("accepted transaction did not start the front multiplier");

    // front multiplier finishes only while the sequencer waits for it
    a_pre_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        pre_done |-> state_reg == ST_PRE)
        else $error("front multiplier done outside its phase");

    // the pose moves only on a write-back that also loads the output
    a_pose_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WB && (!m_axis_tvalid || m_axis_tready)) |=> m_axis_tvalid)
        else $error("write-back without a result");

endmodule

`default_nettype wire

// ----- rtl/odo_pre.sv -----
// ---------------------------------------------------------------------------
// Odometry front multiplier
// Bit-serial heading step and distance product, one count bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module odo_pre import odo_pkg::*; (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          start,
    input  wire  signed [COUNT_W-1:0]    left_count,
    input  wire  signed [COUNT_W-1:0]    right_count,
    input  wire         [CFG_W-1:0]      meters_per_pulse,
    input  wire         [CFG_W-1:0]      turn_per_diff,
    input  wire         [HEAD_W-1:0]     heading_in,
    output logic                         done,
    output logic        [HEAD_W-1:0]     heading_out,
    output logic signed [PROD_W-1:0]     prod
);

    logic [SUM_W-1:0]  diff_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [HEAD_W-1:0] tpd_reg;
    logic [PROD_W-1:0] mpp_reg;
    logic [4:0]        cnt_reg;
    logic              busy_reg;
    logic              last;

    assign last = (cnt_reg == 5'(SUM_W - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done <= !start && busy_reg && last;
            if (start) begin
                diff_reg    <= {right_count[COUNT_W-1], right_count}
                             - {left_count[COUNT_W-1], left_count};
                sum_reg     <= {left_count[COUNT_W-1], left_count}
                             + {right_count[COUNT_W-1], right_count};
                tpd_reg     <= turn_per_diff;
                mpp_reg     <= {{SUM_W{1'b0}}, meters_per_pulse};
                heading_out <= heading_in;
                prod        <= '0;
                cnt_reg     <= '0;
                busy_reg    <= 1'b1;
            end else if (busy_reg) begin
                // sign bit carries negative weight
                if (diff_reg[0])
                    heading_out <= last ? heading_out - tpd_reg : heading_out + tpd_reg;
                if (sum_reg[0])
                    prod <= last ? prod - signed'(mpp_reg) : prod + signed'(mpp_reg);
                diff_reg <= diff_reg >> 1;
                sum_reg  <= sum_reg >> 1;
                tpd_reg  <= tpd_reg << 1;
                mpp_reg  <= mpp_reg << 1;
                cnt_reg  <= cnt_reg + 5'd1;
                if (last)
                    busy_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/odo_cordic.sv -----
// ---------------------------------------------------------------------------
// Odometry CORDIC
// Rotation-mode CORDIC, one micro-rotation per cycle, cosine and sine Q2.30.
// ---------------------------------------------------------------------------
`default_nettype none

module odo_cordic import odo_pkg::*; #(
    parameter int STEPS = 18
) (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       start,
    input  wire        [HEAD_W-1:0]   angle,
    output logic                      done,
    output logic signed [CS_W-1:0]    cos_out,
    output logic signed [CS_W-1:0]    sin_out
);

    localparam int STEPS_EFF = (STEPS > 32) ? 32 : STEPS;

    logic signed [CS_W-1:0] x_reg, y_reg, z_reg;
    logic                   flip_reg;
    logic                   busy_reg;
    logic [STEP_CNT_W-1:0]  i_reg;
    logic signed [CS_W-1:0] xs, ys, atan_ext;
    logic signed [CS_W-1:0] x_next, y_next, z_next;
    logic [1:0]             quad;
    logic                   flip;
    logic [HEAD_W-1:0]      a_rot;

    assign quad  = angle[HEAD_W-1 -: 2];
    assign flip  = (quad == 2'b01) || (quad == 2'b10);
    assign a_rot = flip ? angle + 32'h80000000 : angle;

    always_comb begin
        xs       = x_reg >>> i_reg[4:0];
        ys       = y_reg >>> i_reg[4:0];
        atan_ext = signed'({2'b00, atan_turn(i_reg[4:0])});
        if (z_reg[CS_W-1]) begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + atan_ext;
        end else begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - atan_ext;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            i_reg    <= '0;
        end else begin
            done <= !start && busy_reg && (i_reg == STEP_CNT_W'(STEPS_EFF - 1));
            if (start) begin
                x_reg    <= CORDIC_GAIN_Q30;
                y_reg    <= '0;
                z_reg    <= signed'({{(CS_W-HEAD_W){a_rot[HEAD_W-1]}}, a_rot});
                flip_reg <= flip;
                i_reg    <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                x_reg <= x_next;
                y_reg <= y_next;
                z_reg <= z_next;
                i_reg <= i_reg + STEP_CNT_W'(1);
                if (i_reg == STEP_CNT_W'(STEPS_EFF - 1)) begin
                    busy_reg <= 1'b0;
                    cos_out  <= flip_reg ? -x_next : x_next;
                    sin_out  <= flip_reg ? -y_next : y_next;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/odo_scale.sv -----
// ---------------------------------------------------------------------------
// Odometry scaler
// Bit-serial floor(p * c / 2^31), right-shifting partial sums, one c bit a cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module odo_scale import odo_pkg::*; (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        start,
    input  wire  signed [PROD_W-1:0]   p_in,
    input  wire  signed [CS_W-1:0]     c_in,
    output logic                       done,
    output logic        [POS_W-1:0]    delta
);

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] p_reg;
    logic        [CS_W-1:0]  c_reg;
    logic [STEP_CNT_W-1:0]   cnt_reg;
    logic                    busy_reg;
    logic signed [ACC_W-1:0] addend;
    logic signed [ACC_W-1:0] sum;

    always_comb begin
        addend = '0;
        if (c_reg[0]) begin
            if (cnt_reg < STEP_CNT_W'(FRAC_SHIFT))
                addend = p_reg;
            else if (cnt_reg == STEP_CNT_W'(FRAC_SHIFT))
                addend = p_reg;
            else if (cnt_reg == STEP_CNT_W'(FRAC_SHIFT + 1))
                addend = p_reg <<< 1;
            else
                addend = -(p_reg <<< 2);   // sign bit of c
        end
        sum = acc_reg + addend;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done <= !start && busy_reg && (cnt_reg == STEP_CNT_W'(CS_W - 1));
            if (start) begin
                acc_reg  <= '0;
                p_reg    <= ACC_W'(p_in);
                c_reg    <= c_in;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                // fractional bits shift out, integer-weight bits add in place
                acc_reg <= (cnt_reg < STEP_CNT_W'(FRAC_SHIFT)) ? (sum >>> 1) : sum;
                c_reg   <= c_reg >> 1;
                cnt_reg <= cnt_reg + STEP_CNT_W'(1);
                if (cnt_reg == STEP_CNT_W'(CS_W - 1)) begin
                    busy_reg <= 1'b0;
                    delta    <= sum[POS_W-1:0];
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- test/tb_diff_drive_odometry_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Differential drive odometry testbench
// Streams encoder count pairs into the odometry block under random handshake
// gaps, predicts each pose update with a local fixed-point CORDIC model and
// compares every result field by field. Register settings change between
// phases while the block is idle.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_diff_drive_odometry_top;
    import odo_pkg::*;

    localparam int STEPS      = 18;
    localparam int DRAIN_WAIT = 90;
    localparam int MAX_CYCLES = 1000000;

    // atan(2^-i) in turn units over 2^32, kept locally for the predictor
    localparam logic [31:0] ATAN_TURN [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic [HEAD_W-1:0] heading;
        logic [POS_W-1:0]  pos_y;
        logic [POS_W-1:0]  pos_x;
    } pose_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic [31:0] s_axis_tdata = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [127:0] m_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    diff_drive_odometry_top #(.CORDIC_STEPS(STEPS)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tdata(s_axis_tdata), .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // Predictor copy of the registers and the pose
    logic [31:0] meters_per_pulse;
    logic [31:0] turn_per_diff;
    logic [63:0] pose_x, pose_y;
    logic [31:0] heading;

    logic [31:0] count_pairs[$];   // pending {right, left} pairs to send
    pose_t       pose_expected[$];  // predicted poses not yet seen

    int  errors = 0;
    int  cycles = 0;
    bit  gaps_on = 1'b1;
    int  send_gap = 0;
    int  stall_left = 0;
    bit  in_fired = 1'b0;
    bit  out_fired = 1'b0;

    function automatic logic [63:0] sar(input logic [63:0] v, input int s);
        return $signed(v) >>> s;
    endfunction

    // floor(p * c / 2^31) in 64-bit wrapping arithmetic
    function automatic logic [63:0] scale_mul(input logic [63:0] p, input logic [63:0] c);
        logic [63:0] a, b;
        a = sar(p, 24) * c;
        b = (p & 64'hFFFFFF) * c;
        return sar(a, 7) + sar(((a & 64'd127) << 24) + b, 31);
    endfunction

    // Advance the pose by one encoder pair and return the new pose
    function automatic pose_t advance_pose(input logic [15:0] left, input logic [15:0] right);
        logic [63:0] l, r, sum, diff, x, y, z, xs, ys, prod;
        logic [31:0] ang;
        bit flip;
        pose_t p;
        l = {{48{left[15]}}, left};
        r = {{48{right[15]}}, right};
        sum = l + r;
        diff = r - l;
        heading = heading + 32'(diff * {32'd0, turn_per_diff});
        ang = heading;
        flip = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
        if (flip) ang = ang + 32'h80000000;
        z = {{32{ang[31]}}, ang};
        x = 64'd652032874;
        y = '0;
        for (int i = 0; i < STEPS && i < 32; i++) begin
            xs = sar(x, i);
            ys = sar(y, i);
            if (z[63]) begin
                x = x + ys; y = y - xs; z = z + {32'd0, ATAN_TURN[i]};
            end else begin
                x = x - ys; y = y + xs; z = z - {32'd0, ATAN_TURN[i]};
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        prod = sum * {32'd0, meters_per_pulse};
        pose_x = (pose_x + scale_mul(prod, x)) & 64'hFFFFFFFFFFFF;
        pose_y = (pose_y + scale_mul(prod, y)) & 64'hFFFFFFFFFFFF;
        p.pos_x = pose_x[47:0];
        p.pos_y = pose_y[47:0];
        p.heading = heading;
        return p;
    endfunction

    // Monitor: predict on input transactions, check on output transactions
    always @(posedge aclk) begin
        pose_t got, want;
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("%0t timeout", $time);
            $display("tb_diff_drive_odometry_top: FAIL");
            $finish;
        end
        in_fired <= aresetn && s_axis_tvalid && s_axis_tready;
        out_fired <= aresetn && m_axis_tvalid && m_axis_tready;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (pose_expected.size() == 0) begin
                $display("%0t unexpected result %h", $time, m_axis_tdata);
                errors++;
            end else begin
                want = pose_expected.pop_front();
                if (got.pos_x !== want.pos_x) begin
                    $display("%0t position_x expected %h actual %h",
                             $time, want.pos_x, got.pos_x);
                    errors++;
                end
                if (got.pos_y !== want.pos_y) begin
                    $display("%0t position_y expected %h actual %h",
                             $time, want.pos_y, got.pos_y);
                    errors++;
                end
                if (got.heading !== want.heading) begin
                    $display("%0t heading expected %h actual %h",
                             $time, want.heading, got.heading);
                    errors++;
                end
            end
        end
        if (aresetn && s_axis_tvalid && s_axis_tready)
            pose_expected.push_back(advance_pose(s_axis_tdata[15:0], s_axis_tdata[31:16]));
    end

    // Driver: one nonblocking update per signal on each falling edge
    always @(negedge aclk) begin
        logic nxt_valid;
        logic [31:0] nxt_data;
        logic nxt_ready;
        nxt_valid = s_axis_tvalid;
        nxt_data = s_axis_tdata;
        if (aresetn) begin
            // hold the current transaction until it is taken
            if (!s_axis_tvalid || in_fired) begin
                nxt_valid = 1'b0;
                if (in_fired) send_gap = gaps_on ? $urandom_range(0, 4) : 0;
                if (send_gap > 0) begin
                    send_gap--;
                end else if (count_pairs.size() > 0) begin
                    nxt_data = count_pairs.pop_front();
                    nxt_valid = 1'b1;
                end
            end
        end
        // stall the result side a random number of cycles after each transaction
        if (out_fired) stall_left = gaps_on ? $urandom_range(0, 4) : 0;
        if (stall_left > 0) begin
            stall_left--;
            nxt_ready = 1'b0;
        end else begin
            nxt_ready = aresetn;
        end
        s_axis_tvalid <= nxt_valid;
        s_axis_tdata <= nxt_data;
        m_axis_tready <= nxt_ready;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_METERS_PER_PULSE) meters_per_pulse = val;
        else if (idx == REG_TURN_PER_DIFF) turn_per_diff = val;
    endtask

    // Wait until every expected pose has come back, then let the block settle
    task automatic drain();
        while (count_pairs.size() > 0 || s_axis_tvalid || pose_expected.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic send(input logic [15:0] left, input logic [15:0] right);
        count_pairs.push_back({right, left});
    endtask

    task automatic random_pairs(input int n);
        logic [15:0] l, r;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                // small counts, as seen at normal control-loop rates
                l = 16'($signed($urandom_range(0, 400)) - 200);
                r = 16'($signed($urandom_range(0, 400)) - 200);
            end else begin
                l = 16'($urandom);
                r = 16'($urandom);
            end
            send(l, r);
        end
    endtask

    initial begin
        meters_per_pulse = METERS_PER_PULSE_RST;
        turn_per_diff = TURN_PER_DIFF_RST;
        pose_x = '0;
        pose_y = '0;
        heading = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: reset registers, count extremes, first sample
        send(16'd0, 16'd0);
        send(16'h7FFF, 16'h7FFF);
        send(16'h8000, 16'h8000);
        send(16'h7FFF, 16'h8000);
        send(16'h8000, 16'h7FFF);
        send(16'h0001, 16'hFFFF);
        send(16'hFFFF, 16'h0001);
        send(16'h5555, 16'hAAAA);
        drain();

        // Quarter-turn steps walk the heading through every quadrant and wrap
        write_reg(REG_TURN_PER_DIFF, 32'h40000000);
        write_reg(REG_METERS_PER_PULSE, 32'hFFFFFFFF);
        for (int i = 0; i < 6; i++) send(16'd0, 16'd1);
        // maximum distance drives the position accumulators past their range
        for (int i = 0; i < 6; i++) send(16'h7FFF, 16'h7FFF);
        drain();

        // Zero registers: no distance and no turning
        write_reg(REG_METERS_PER_PULSE, 32'd0);
        write_reg(REG_TURN_PER_DIFF, 32'd0);
        write_reg(2'd2, 32'hDEADBEEF);   // indexes past the list are ignored
        write_reg(2'd3, 32'h12345678);
        send(16'h7FFF, 16'h8000);
        send(16'h1234, 16'h4321);
        drain();

        write_reg(REG_TURN_PER_DIFF, 32'hFFFFFFFF);
        write_reg(REG_METERS_PER_PULSE, 32'h80000000);
        send(16'h8000, 16'h7FFF);
        send(16'h7FFF, 16'h8000);
        drain();

        // Random phases with varied settings, one without handshake gaps
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: write_reg(REG_METERS_PER_PULSE, METERS_PER_PULSE_RST);
                1: write_reg(REG_METERS_PER_PULSE, 32'hFFFFFFFF);
                default: write_reg(REG_METERS_PER_PULSE, $urandom);
            endcase
            case (ph)
                0: write_reg(REG_TURN_PER_DIFF, TURN_PER_DIFF_RST);
                1: write_reg(REG_TURN_PER_DIFF, 32'hFFFFFFFF);
                2: write_reg(REG_TURN_PER_DIFF, 32'd0);
                default: write_reg(REG_TURN_PER_DIFF, $urandom);
            endcase
            write_reg(2'($urandom_range(2, 3)), $urandom);
            gaps_on = (ph != 3);
            random_pairs(250);
            drain();
        end

        if (errors == 0) begin
            $display("tb_diff_drive_odometry_top: PASS");
        end else begin
            $display("tb_diff_drive_odometry_top: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
